### src/pvas_pkg.sv
// package: shared types, constants and cordic step functions for the polar vector add/sub core
package pvas_pkg;

  localparam int unsigned CW = 37;
  localparam int unsigned AW = 32;
  localparam int unsigned TABLE_LEN = 24;
  localparam logic [31:0] INV_GAIN = 32'h9B74_EDA8;
  localparam logic [AW-1:0] HALF_TURN = 32'h8000_0000;

  localparam logic [AW-1:0] ATAN_TABLE [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } op_e;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t        x;
    coord_t        y;
    logic [AW-1:0] z;
  } rot_vec_t;

  typedef struct packed {
    op_e      op;
    rot_vec_t a;
    rot_vec_t b;
  } rot_pair_t;

  typedef struct packed {
    logic          zero;
    coord_t        s;
    coord_t        c;
    logic [AW-1:0] z;
  } vec_state_t;

  typedef struct packed {
    logic [15:0] angle;
    logic [16:0] length;
  } result_t;

  // one rotation-mode micro-rotation, z driven toward zero
  function automatic rot_vec_t rot_step(rot_vec_t v, int unsigned sh, logic [AW-1:0] ang);
    rot_vec_t r;
    coord_t   dc;
    coord_t   ds;
    dc = v.x >>> sh;
    ds = v.y >>> sh;
    if (v.z[AW-1]) begin
      r.y = v.y + dc;
      r.x = v.x - ds;
      r.z = v.z + ang;
    end else begin
      r.y = v.y - dc;
      r.x = v.x + ds;
      r.z = v.z - ang;
    end
    return r;
  endfunction

  // one vectoring-mode micro-rotation, s driven toward zero
  function automatic vec_state_t vec_step(vec_state_t v, int unsigned sh, logic [AW-1:0] ang);
    vec_state_t r;
    coord_t     dc;
    coord_t     ds;
    dc = v.s >>> sh;
    ds = v.c >>> sh;
    r.zero = v.zero;
    if (!v.s[CW-1] && (v.s != '0)) begin
      r.c = v.c + dc;
      r.s = v.s - ds;
      r.z = v.z + ang;
    end else begin
      r.c = v.c - dc;
      r.s = v.s + ds;
      r.z = v.z - ang;
    end
    return r;
  endfunction

endpackage

### src/polar_vector_add_sub_core.sv
// top level: polar vector add/sub core with pipelined rotation and vectoring cordic chains
//
// Input channel (in_valid_i/in_ready_o) moves one transfer per item: an operation
// select and two polar vectors (signed half-turn angle, unsigned Q8.8 length).
// Output channel (out_valid_o/out_ready_i) moves one transfer per item: the angle
// and Q9.8 length of the sum or difference, in input order.
// From input transfer to out_valid_o an item passes stages 1 and 2, the rotation
// chain, stages 3 and 4, the vectoring chain, stages 5 and 6 and the output register.
// Throughput is one item per cycle while the skid register is empty; every stage is a
// register, the rotation and vectoring chains each hold one cell per cordic iteration.
// The output holds a result register plus one skid register. When the receiver
// stalls, the pipeline keeps advancing until an item enters the skid register and
// then freezes as a whole; in_ready_o drops only while the skid register is full.
// Reset clears all valid bits, so the block comes up empty with in_ready_o high.
// The block keeps no state between items.
module polar_vector_add_sub_core
  import pvas_pkg::*;
#(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [15:0] first_angle_i,
  input  logic [15:0] first_length_i,
  input  logic [15:0] second_angle_i,
  input  logic [15:0] second_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_angle_o,
  output logic [16:0] result_length_o
);

  localparam int unsigned N = CORDIC_ITERATIONS;

  logic en;

  // stage 1: start coordinates from length times inverse gain
  logic          s1_valid_q;
  op_e           s1_op_q;
  logic [AW-1:0] s1_za_q, s1_zb_q;
  coord_t        s1_ca_q, s1_cb_q;
  logic [47:0]   prod_a, prod_b;

  assign prod_a = 48'(first_length_i) * 48'(INV_GAIN) + 48'h8000;
  assign prod_b = 48'(second_length_i) * 48'(INV_GAIN) + 48'h8000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q <= op_e'(operation_i);
      s1_za_q <= {first_angle_i, 16'h0000};
      s1_zb_q <= {second_angle_i, 16'h0000};
      s1_ca_q <= coord_t'({{(CW-32){1'b0}}, prod_a[47:16]});
      s1_cb_q <= coord_t'({{(CW-32){1'b0}}, prod_b[47:16]});
    end
  end

  // stage 2: fold angles beyond a quarter turn
  logic      rot_valid [N+1];
  rot_pair_t rot_data  [N+1];
  logic      s2_valid_q;
  rot_pair_t s2_d, s2_q;

  always_comb begin
    s2_d.op   = s1_op_q;
    s2_d.a.x  = '0;
    s2_d.b.x  = '0;
    s2_d.a.y  = s1_ca_q;
    s2_d.a.z  = s1_za_q;
    s2_d.b.y  = s1_cb_q;
    s2_d.b.z  = s1_zb_q;
    if (s1_za_q[AW-1] != s1_za_q[AW-2]) begin
      s2_d.a.y = -s1_ca_q;
      s2_d.a.z = s1_za_q + HALF_TURN;
    end
    if (s1_zb_q[AW-1] != s1_zb_q[AW-2]) begin
      s2_d.b.y = -s1_cb_q;
      s2_d.b.z = s1_zb_q + HALF_TURN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q <= s2_d;
    end
  end

  assign rot_valid[0] = s2_valid_q;
  assign rot_data[0]  = s2_q;

  for (genvar g = 0; g < N; g++) begin : g_rot
    pvas_rot_cell #(
      .STAGE(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(rot_valid[g]),
      .data_i (rot_data[g]),
      .valid_o(rot_valid[g+1]),
      .data_o (rot_data[g+1])
    );
  end

  // stage 3: add or subtract coordinates
  logic   s3_valid_q;
  coord_t s3_s_q, s3_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= rot_valid[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (rot_data[N].op == OP_SUB) begin
        s3_s_q <= rot_data[N].a.x - rot_data[N].b.x;
        s3_c_q <= rot_data[N].a.y - rot_data[N].b.y;
      end else begin
        s3_s_q <= rot_data[N].a.x + rot_data[N].b.x;
        s3_c_q <= rot_data[N].a.y + rot_data[N].b.y;
      end
    end
  end

  // stage 4: zero check and half-plane fold before vectoring
  logic       vec_valid [N+1];
  vec_state_t vec_data  [N+1];
  logic       s4_valid_q;
  vec_state_t s4_d, s4_q;

  always_comb begin
    s4_d.zero = (s3_s_q == '0) && (s3_c_q == '0);
    if (s3_c_q[CW-1]) begin
      s4_d.s = -s3_s_q;
      s4_d.c = -s3_c_q;
      s4_d.z = HALF_TURN;
    end else begin
      s4_d.s = s3_s_q;
      s4_d.c = s3_c_q;
      s4_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q <= s4_d;
    end
  end

  assign vec_valid[0] = s4_valid_q;
  assign vec_data[0]  = s4_q;

  for (genvar g = 0; g < N; g++) begin : g_vec
    pvas_vec_cell #(
      .STAGE(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(vec_valid[g]),
      .data_i (vec_data[g]),
      .valid_o(vec_valid[g+1]),
      .data_o (vec_data[g+1])
    );
  end

  // stage 5: gain correction multiply
  logic          s5_valid_q;
  logic          s5_zero_q;
  logic [AW-1:0] s5_z_q;
  logic [63:0]   s5_prod_q;
  logic [CW-6:0] mag;

  assign mag = vec_data[N].c[CW-1] ? '0 : vec_data[N].c[CW-2:4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s5_valid_q <= vec_valid[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_zero_q <= vec_data[N].zero;
      s5_z_q    <= vec_data[N].z;
      s5_prod_q <= 64'(mag) * 64'(INV_GAIN);
    end
  end

  // stage 6: rounding and clamp
  logic        s6_valid_q;
  result_t     s6_d, s6_q;
  logic [63:0] len_sum;
  logic [31:0] ang_sum;

  assign len_sum = s5_prod_q + (64'd1 << 43);
  assign ang_sum = s5_z_q + 32'h0000_8000;

  always_comb begin
    if (s5_zero_q) begin
      s6_d.angle  = '0;
      s6_d.length = '0;
    end else begin
      s6_d.angle  = ang_sum[31:16];
      s6_d.length = (len_sum[63:61] != '0) ? 17'h1FFFF : len_sum[60:44];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (en) begin
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q <= s6_d;
    end
  end

  // output register with skid
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    incoming;

  assign en       = !skid_valid_q;
  assign incoming = en && s6_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_valid_q && !out_ready_i) begin
      if (incoming) begin
        skid_valid_d = 1'b1;
        skid_d       = s6_q;
      end
    end else if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d = incoming;
      out_d       = s6_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_ready_o      = en;
  assign out_valid_o     = out_valid_q;
  assign result_angle_o  = out_q.angle;
  assign result_length_o = out_q.length;

endmodule

### src/pvas_rot_cell.sv
// rotation cell: one cordic rotation step for both input vectors
module pvas_rot_cell
  import pvas_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  rot_pair_t data_i,
  output logic      valid_o,
  output rot_pair_t data_o
);

  logic      valid_q;
  rot_pair_t data_q;
  rot_pair_t data_d;

  always_comb begin
    data_d.op = data_i.op;
    data_d.a  = rot_step(data_i.a, STAGE, ATAN_TABLE[STAGE]);
    data_d.b  = rot_step(data_i.b, STAGE, ATAN_TABLE[STAGE]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### src/pvas_vec_cell.sv
// vectoring cell: one cordic vectoring step on the combined vector
module pvas_vec_cell
  import pvas_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  vec_state_t data_i,
  output logic       valid_o,
  output vec_state_t data_o
);

  logic       valid_q;
  vec_state_t data_q;
  vec_state_t data_d;

  assign data_d = vec_step(data_i, STAGE, ATAN_TABLE[STAGE]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sim/polar_vector_add_sub_core_tb.sv
// testbench: polar vector add/sub core checked against a bit-exact cordic predictor
module polar_vector_add_sub_core_tb;
  import pvas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITERS   = 16;
  localparam int unsigned STAGES  = (ITERS > TABLE_LEN) ? TABLE_LEN : ITERS;
  localparam int unsigned LATENCY = 2 * ITERS + 7;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic        operation     = 1'b0;
  logic [15:0] first_angle   = '0;
  logic [15:0] first_length  = '0;
  logic [15:0] second_angle  = '0;
  logic [15:0] second_length = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [15:0] result_angle;
  logic [16:0] result_length;

  result_t     pending_sums [$];
  int unsigned mismatches     = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_left      = 0;

  polar_vector_add_sub_core #(
    .CORDIC_ITERATIONS(ITERS)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .first_angle_i  (first_angle),
    .first_length_i (first_length),
    .second_angle_i (second_angle),
    .second_length_i(second_length),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_angle_o (result_angle),
    .result_length_o(result_length)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // polar to cartesian, lsb 2^-24
  function automatic void to_xy(input logic [15:0] ang, input logic [15:0] len,
                                output longint x, output longint y);
    logic [31:0] z;
    logic [63:0] prod;
    longint      c;
    longint      s;
    longint      dc;
    longint      ds;
    z = {ang, 16'h0000};
    prod = 64'(len) * 64'(INV_GAIN) + 64'h8000;
    c = longint'(prod >> 16);
    s = 0;
    if (z[31] != z[30]) begin
      c = -c;
      z = z + HALF_TURN;
    end
    for (int i = 0; i < STAGES; i++) begin
      dc = s >>> i;
      ds = c >>> i;
      if (z[31]) begin
        c = c + dc;
        s = s - ds;
        z = z + ATAN_TABLE[i];
      end else begin
        c = c - dc;
        s = s + ds;
        z = z - ATAN_TABLE[i];
      end
    end
    x = s;
    y = c;
  endfunction

  function automatic result_t polar_sum(input op_e op, input logic [15:0] a1, l1, a2, l2);
    longint      x1;
    longint      y1;
    longint      x2;
    longint      y2;
    longint      s;
    longint      c;
    longint      dc;
    longint      ds;
    logic [31:0] z;
    logic [63:0] cu;
    logic [63:0] mag;
    logic [32:0] zr;
    result_t     r;
    to_xy(a1, l1, x1, y1);
    to_xy(a2, l2, x2, y2);
    if (op == OP_SUB) begin
      s = x1 - x2;
      c = y1 - y2;
    end else begin
      s = x1 + x2;
      c = y1 + y2;
    end
    r = '0;
    if (s == 0 && c == 0) return r;
    z = '0;
    if (c < 0) begin
      c = -c;
      s = -s;
      z = HALF_TURN;
    end
    for (int i = 0; i < STAGES; i++) begin
      dc = s >>> i;
      ds = c >>> i;
      if (s > 0) begin
        c = c + dc;
        s = s - ds;
        z = z + ATAN_TABLE[i];
      end else begin
        c = c - dc;
        s = s + ds;
        z = z - ATAN_TABLE[i];
      end
    end
    if (c < 0) c = 0;
    cu = c;
    mag = ((cu >> 4) * 64'(INV_GAIN) + (64'd1 << 43)) >> 44;
    if (mag > 64'd131071) mag = 64'd131071;
    zr = {1'b0, z} + 33'h0_0000_8000;
    r.angle = zr[31:16];
    r.length = mag[16:0];
    return r;
  endfunction

  task automatic send_pair(input op_e op, input logic [15:0] a1, l1, a2, l2);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    first_angle   <= a1;
    first_length  <= l1;
    second_angle  <= a2;
    second_length <= l2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_sums.push_back(polar_sum(op, a1, l1, a2, l2));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h4000;
      3: return 16'hC000;
      4: return 16'h3FFF;
      5: return 16'hBFFF;
      6: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver ready, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t exp_sum;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        mismatches++;
        $display("%0t unexpected transfer angle %0d length %0d", $time,
                 $signed(result_angle), result_length);
      end else begin
        exp_sum = pending_sums.pop_front();
        if (result_angle !== exp_sum.angle) begin
          mismatches++;
          $display("%0t angle mismatch expected %0d actual %0d", $time,
                   $signed(exp_sum.angle), $signed(result_angle));
        end
        if (result_length !== exp_sum.length) begin
          mismatches++;
          $display("%0t length mismatch expected %0d actual %0d", $time,
                   exp_sum.length, result_length);
        end
      end
    end
  end

  task automatic test_directed();
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    send_pair(OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pair(OP_SUB, 16'h1234, 16'h0500, 16'h1234, 16'h0500);
    send_pair(OP_ADD, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_pair(OP_ADD, 16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF);
    send_pair(OP_SUB, 16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF);
    send_pair(OP_ADD, 16'h8000, 16'h0100, 16'h0000, 16'h0000);
    send_pair(OP_ADD, 16'h7FFF, 16'h0100, 16'h0000, 16'h0000);
    send_pair(OP_ADD, 16'h4000, 16'h0200, 16'h0000, 16'h0000);
    send_pair(OP_ADD, 16'hC000, 16'h0200, 16'h0000, 16'h0000);
    send_pair(OP_ADD, 16'h3FFF, 16'h0300, 16'hBFFF, 16'h0300);
    send_pair(OP_SUB, 16'h4001, 16'h0300, 16'hC001, 16'h0100);
    send_pair(OP_ADD, 16'h6000, 16'h0800, 16'h9000, 16'h0400);
    send_pair(OP_ADD, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
    send_pair(OP_SUB, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
    send_pair(OP_ADD, 16'h0000, 16'h0100, 16'h8000, 16'h0100);
    send_pair(OP_SUB, 16'h2000, 16'hFFFF, 16'hE000, 16'hFFFF);
    send_pair(OP_ADD, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF);
    send_pair(OP_SUB, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_pair(OP_ADD, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    send_pair(OP_SUB, 16'h8000, 16'h0100, 16'h0000, 16'h0100);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned src_pct,
                             input int unsigned sink_pct);
    op_e         op;
    logic [15:0] a1;
    logic [15:0] l1;
    logic [15:0] a2;
    logic [15:0] l2;
    src_idle_pct = src_pct;
    sink_stall_pct <= sink_pct;
    for (int n = 0; n < count; n++) begin
      op = op_e'($urandom_range(0, 1));
      a1 = pick_angle();
      l1 = pick_length();
      a2 = pick_angle();
      l2 = pick_length();
      case ($urandom_range(0, 15))
        0: begin
          a2 = a1;
          l2 = l1;
        end
        1: begin
          a2 = a1 + 16'h8000;
          l2 = l1;
        end
        2: a2 = a1 + 16'($urandom_range(0, 3)) - 16'd1;
        default: ;
      endcase
      send_pair(op, a1, l1, a2, l2);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    hold_left <= 400;
    for (int n = 0; n < 120; n++) begin
      send_pair(op_e'($urandom_range(0, 1)), pick_angle(), pick_length(),
                pick_angle(), pick_length());
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300, 0, 0);
    test_random(250, 71, 0);
    test_random(250, 0, 71);
    test_random(250, 31, 31);
    test_backpressure();
    repeat (2 * LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
